// File: rtl/uss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uss_pkg: shared types and helpers of the UTF-8 sentence splitter
// Beat types, register indexes, character classes, and the lead-byte and
// code-point decode functions used by the splitter datapath.
// ----------------------------------------------------------------------------
package uss_pkg;

	localparam int CHAR_BYTES = 8;
	localparam int IDX_W      = 3;
	localparam int FILL_W     = 4;
	localparam int LEN_W      = 16;
	localparam int OUT_PARA_W = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int CP_W       = 50;

	localparam logic [CP_W-1:0]  HAN_LOW        = CP_W'(19968);
	localparam logic [CP_W-1:0]  HAN_HIGH       = CP_W'(40907);
	localparam logic [LEN_W:0]   UNKNOWN_MARGIN = 17'd500;
	localparam logic [LEN_W:0]   HAN_MARGIN     = 17'd10;
	localparam logic [7:0]       NEWLINE_BYTE   = 8'd10;
	localparam logic [LEN_W-1:0] LEN_MAX        = 16'hFFFF;
	localparam logic [LEN_W-1:0] MAX_BYTES_RST  = 16'd1024;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_BYTES = 2'd0,
		REG_STRATEGY  = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CLS_HAN     = 2'd0,
		CLS_UNKNOWN = 2'd1,
		CLS_NEWLINE = 2'd2
	} char_class_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_in_article;
	} in_item_t;

	typedef struct packed {
		logic                  item_kind;
		logic [7:0]            out_byte;
		logic [OUT_PARA_W-1:0] paragraph_number;
		logic                  last_of_run;
	} out_item_t;

	// results caused by one input byte: kept bytes, then an optional end marker
	typedef struct packed {
		logic [CHAR_BYTES-1:0][7:0] bytes;
		logic [FILL_W-1:0]          nbytes;
		logic                       marker;
		logic [OUT_PARA_W-1:0]      para;
	} bundle_t;

	// character length from the lead byte: one byte for ASCII, else one byte per leading one bit
	function automatic logic [FILL_W-1:0] lead_length(input logic [7:0] lead);
		logic [FILL_W-1:0] n;
		logic              run;
		n   = '0;
		run = 1'b1;
		if (!lead[7]) begin
			n = FILL_W'(1);
		end else begin
			for (int k = 0; k < 8; k++) begin
				if (run && lead[7-k]) begin
					n = n + FILL_W'(1);
				end else begin
					run = 1'b0;
				end
			end
		end
		return n;
	endfunction

	// decode the code point of the held bytes and sort it into a class
	function automatic char_class_t classify_char(
		input logic [CHAR_BYTES-1:0][7:0] cb,
		input logic [FILL_W-1:0]          size
	);
		logic [7:0]      lead;
		logic [CP_W-1:0] cp;
		logic [2:0]      pp;
		logic            run;
		logic [7:0]      mask;
		char_class_t     cls;
		lead = cb[0];
		cp   = '0;
		pp   = '0;
		run  = 1'b1;
		mask = '0;
		if (!lead[7]) begin
			cls = (lead == NEWLINE_BYTE) ? CLS_NEWLINE : CLS_HAN;
		end else begin
			// gather continuation payloads while the lead keeps announcing them
			for (int k = 0; k < 7; k++) begin
				if (run && (FILL_W'(k + 1) < size) && lead[6-k]) begin
					pp = 3'(k + 1);
					cp = {cp[CP_W-7:0], cb[k+1][5:0]};
				end else begin
					run = 1'b0;
				end
			end
			if (pp == 3'd7) begin
				mask = 8'hFF;
			end else begin
				mask = (8'd64 >> pp) - 8'd1;
			end
			cp  = cp | (CP_W'(lead & mask) << (int'(pp) * 6));
			cls = (cp >= HAN_LOW && cp <= HAN_HIGH) ? CLS_HAN : CLS_UNKNOWN;
		end
		return cls;
	endfunction

endpackage

// File: rtl/utf8_sentence_splitter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_sentence_splitter_unit: byte-serial UTF-8 sentence splitter
// Groups article bytes into characters, classifies them and emits the kept
// bytes of each sentence followed by an end marker.
// ----------------------------------------------------------------------------
// An input byte is registered, then handled combinationally: the character is
// assembled, decoded and classified, and the sentence state is updated. The
// results it causes go to a result emitter that gives one beat per cycle while
// out_ready is high. A byte that causes no result never waits for the emitter;
// a byte that causes k results (up to 9: eight bytes of a long character and an
// end marker) keeps the emitter busy until its last result is taken, and the
// next byte with results waits for the emitter to free up. Configuration writes
// are always ready and take effect on the next byte.
module utf8_sentence_splitter_unit import uss_pkg::*; #(
	parameter int PARAGRAPH_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [PARAGRAPH_BITS-1:0] PARA_MAX = {PARAGRAPH_BITS{1'b1}};
	localparam logic [PARAGRAPH_BITS-1:0] PARA_ONE = PARAGRAPH_BITS'(1);

	// input stage
	logic     in_valid_s1;
	in_item_t in_item_s1;

	// configuration
	logic [LEN_W-1:0] max_bytes_q;
	logic             strategy_q;

	// splitter state
	logic                            collecting_q;
	logic [CHAR_BYTES-1:0][7:0]      char_bytes_q;
	logic [FILL_W-1:0]               char_fill_q;
	logic [FILL_W-1:0]               char_expected_q;
	logic [LEN_W-1:0]                sentence_length_q;
	logic [PARAGRAPH_BITS-1:0]       paragraph_count_q;
	logic [PARAGRAPH_BITS-1:0]       sentence_paragraph_q;
	logic                            skip_nl_seen_q;

	// next state
	logic                            nxt_collecting;
	logic [FILL_W-1:0]               nxt_fill;
	logic [FILL_W-1:0]               nxt_expected;
	logic [LEN_W-1:0]                nxt_length;
	logic [PARAGRAPH_BITS-1:0]       nxt_para;
	logic [PARAGRAPH_BITS-1:0]       nxt_spara;
	logic                            nxt_skip_nl;

	logic [CHAR_BYTES-1:0][7:0]      cur_bytes;
	logic [FILL_W-1:0]               expected;
	logic [FILL_W-1:0]               fill_next;
	logic                            char_done;
	char_class_t                     cls;
	logic                            opened;
	logic                            stop;
	logic [LEN_W-1:0]                len_eff;
	logic [LEN_W:0]                  len_sum;
	logic [FILL_W-1:0]               emit_n;
	logic                            marker;
	logic [PARAGRAPH_BITS-1:0]       run_para;
	logic                            has_results;
	logic                            advance;
	logic                            load_ready;
	bundle_t                         bundle;

	// assemble the character with the incoming byte
	always_comb begin
		cur_bytes = char_bytes_q;
		cur_bytes[char_fill_q[IDX_W-1:0]] = in_item_s1.data_byte;
		expected  = (char_fill_q == '0) ? lead_length(in_item_s1.data_byte) : char_expected_q;
		fill_next = char_fill_q + FILL_W'(1);
		char_done = (fill_next >= expected) || in_item_s1.last_in_article;
		cls       = classify_char(cur_bytes, fill_next);
	end

	// skip and collect decisions
	always_comb begin
		nxt_collecting = collecting_q;
		nxt_fill       = fill_next;
		nxt_expected   = expected;
		nxt_length     = sentence_length_q;
		nxt_para       = paragraph_count_q;
		nxt_spara      = sentence_paragraph_q;
		nxt_skip_nl    = skip_nl_seen_q;
		opened         = 1'b0;
		stop           = 1'b0;
		len_eff        = collecting_q ? sentence_length_q : '0;
		len_sum        = '0;
		emit_n         = '0;
		marker         = 1'b0;

		if (char_done) begin
			nxt_fill     = '0;
			nxt_expected = '0;
			// skipping phase: count the first newline, open on Han
			if (!collecting_q) begin
				if (cls == CLS_NEWLINE && !skip_nl_seen_q) begin
					nxt_skip_nl = 1'b1;
					if (paragraph_count_q != PARA_MAX) begin
						nxt_para = paragraph_count_q + PARA_ONE;
					end
				end
				if (cls == CLS_HAN) begin
					opened         = 1'b1;
					nxt_collecting = 1'b1;
					nxt_length     = '0;
					nxt_spara      = paragraph_count_q;
				end
			end
			if (collecting_q || opened) begin
				case (cls)
					CLS_NEWLINE: begin
						if (paragraph_count_q != PARA_MAX) begin
							nxt_para = paragraph_count_q + PARA_ONE;
						end
						stop = len_eff != '0;
					end
					CLS_UNKNOWN: begin
						if (strategy_q) begin
							stop = len_eff != '0;
						end else begin
							stop = (max_bytes_q != '0) &&
							       ({1'b0, len_eff} + UNKNOWN_MARGIN > {1'b0, max_bytes_q});
						end
					end
					default: begin
						stop       = (max_bytes_q != '0) &&
						             ({1'b0, len_eff} + HAN_MARGIN > {1'b0, max_bytes_q});
						emit_n     = fill_next;
						len_sum    = {1'b0, len_eff} + (LEN_W + 1)'(fill_next);
						nxt_length = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
					end
				endcase
				if (stop) begin
					marker         = 1'b1;
					nxt_collecting = 1'b0;
					nxt_skip_nl    = 1'b0;
				end
			end
		end

		run_para = nxt_spara;

		// end of article: close an open sentence and start afresh
		if (in_item_s1.last_in_article) begin
			if (nxt_collecting) begin
				marker = 1'b1;
			end
			nxt_collecting = 1'b0;
			nxt_fill       = '0;
			nxt_expected   = '0;
			nxt_length     = '0;
			nxt_para       = PARA_ONE;
			nxt_spara      = PARA_ONE;
			nxt_skip_nl    = 1'b0;
		end
	end

	assign has_results   = (emit_n != '0) || marker;
	assign advance       = in_valid_s1 && (load_ready || !has_results);
	assign in_ready      = !in_valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	always_comb begin
		bundle.bytes  = cur_bytes;
		bundle.nbytes = emit_n;
		bundle.marker = marker;
		bundle.para   = OUT_PARA_W'(run_para);
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_item_s1 <= in_item;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= MAX_BYTES_RST;
			strategy_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MAX_BYTES: max_bytes_q <= cfg_data;
				REG_STRATEGY:  strategy_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// splitter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q         <= 1'b0;
			char_fill_q          <= '0;
			char_expected_q      <= '0;
			sentence_length_q    <= '0;
			paragraph_count_q    <= PARA_ONE;
			sentence_paragraph_q <= PARA_ONE;
			skip_nl_seen_q       <= 1'b0;
		end else if (advance) begin
			collecting_q         <= nxt_collecting;
			char_fill_q          <= nxt_fill;
			char_expected_q      <= nxt_expected;
			sentence_length_q    <= nxt_length;
			paragraph_count_q    <= nxt_para;
			sentence_paragraph_q <= nxt_spara;
			skip_nl_seen_q       <= nxt_skip_nl;
		end
	end

	// character byte store
	always_ff @(posedge clk) begin
		if (advance) begin
			char_bytes_q[char_fill_q[IDX_W-1:0]] <= in_item_s1.data_byte;
		end
	end

	uss_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (in_valid_s1 && has_results),
		.load_ready (load_ready),
		.load_data  (bundle),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

endmodule

// File: rtl/uss_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uss_emitter: result serializer
// Holds the results caused by one input byte and hands them out one beat per
// cycle while out_ready is high: kept bytes in order, then any end marker.
// ----------------------------------------------------------------------------
module uss_emitter import uss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load_valid,
	output logic      load_ready,
	input  bundle_t   load_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic              full_q;
	logic [FILL_W-1:0] idx_q;
	bundle_t           bundle_q;
	logic              is_byte;
	logic              final_beat;
	logic              done;

	// select the current beat
	always_comb begin
		is_byte    = idx_q < bundle_q.nbytes;
		final_beat = is_byte ? ((idx_q + FILL_W'(1) == bundle_q.nbytes) && !bundle_q.marker)
		                     : 1'b1;
		out_item.item_kind        = is_byte ? KIND_BYTE : KIND_END;
		out_item.out_byte         = is_byte ? bundle_q.bytes[idx_q[IDX_W-1:0]] : 8'd0;
		out_item.paragraph_number = bundle_q.para;
		out_item.last_of_run      = final_beat;
	end

	assign out_valid  = full_q;
	assign done       = full_q && out_ready && final_beat;
	assign load_ready = !full_q || done;

	// hold the bundle and advance through its beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			idx_q  <= '0;
		end else if (load_valid && load_ready) begin
			full_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			full_q <= 1'b0;
		end else if (full_q && out_ready) begin
			idx_q <= idx_q + FILL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			bundle_q <= load_data;
		end
	end

endmodule

// File: rtl/uss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uss_checker: port-level checks of the sentence splitter
// Watches the input and result channels for stalls, burst shape and marker
// placement.
// ----------------------------------------------------------------------------
module uss_checker import uss_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_item,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	// hold a stalled input beat
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_item))
		else $error("input beat changed while stalled");

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result beat changed while stalled");

	// end marker closes its run and carries no byte
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.item_kind == KIND_END |->
			out_item.last_of_run && out_item.out_byte == 8'd0)
		else $error("end marker not last of run or has a byte");

	// a run continues without a gap
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_item.last_of_run |=> out_valid)
		else $error("gap inside a result run");

	// paragraph number holds within a run
	a_run_para: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_item.last_of_run |=>
			out_item.paragraph_number == $past(out_item.paragraph_number))
		else $error("paragraph number changed inside a run");

endmodule

bind utf8_sentence_splitter_unit uss_checker u_uss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
